// File: rtl/srbsc_pkg.sv
// Shared types and constants for the self-rekeying byte stream cipher.
package srbsc_pkg;

   // Key ring geometry
   localparam int KEY_AW    = 8;
   localparam int KEY_BYTES = 1 << KEY_AW;
   localparam int SPAN_W    = KEY_AW + 1;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int SEED_W   = 64;
   localparam int MUL_W    = 32;
   localparam int ADD_W    = 16;
   localparam int LEN_W    = 9;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 9;
   localparam int REQ_DW   = 24;
   localparam int REQ_UW   = 3;
   localparam int LOW_N    = 8;
   localparam int LOW_AW   = 3;

   // Seed recurrence taps
   localparam int MUL_LSB  = 8;
   localparam int ADD_LSB  = 40;
   localparam int TOP_LSB  = 56;

   localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(8);

   // Item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_KEY_WRITE = 2'd0,
      CMD_SEED_LOAD = 2'd1,
      CMD_DATA      = 2'd2
   } cmd_type;

   // Configuration register indexes
   localparam logic [CSR_IW-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_DIRECTION = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_KEY_LEN   = 2'd2;

   // Active key span: zero counts as one, saturates at the ring size
   function automatic logic [SPAN_W-1:0] span_of(input logic [LEN_W-1:0] len);
      logic [SPAN_W-1:0] s;
      if (len == '0) begin
         s = SPAN_W'(1);
      end else if (32'(len) > KEY_BYTES) begin
         s = SPAN_W'(KEY_BYTES);
      end else begin
         s = SPAN_W'(len);
      end
      return s;
   endfunction

endpackage

// File: rtl/self_rekeying_byte_stream_cipher.sv
// Top level of the self-rekeying byte stream cipher: key ring, seed and data path.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  req_*    | in        | tdata: key_index, key_value, data_byte; tuser: cmd, first_of_call
//  rsp_*    | out       | tdata: data_out (one transaction per data byte)
//  csr_*    | in        | write enable, register index, write data
//
// One transaction is taken per cycle while req_tready is high; a data byte's ring read and
// work stage load happen at acceptance, and its result is then registered in the result
// register when the work stage advances. The seed recurrence (one 32x32 full and one
// 32x32 low-half product) is combinational into the seed register.
// Reset clears the seed, key position, pipeline valids and configuration; the key
// ring holds garbage until written. A stalled rsp side stalls req only when the
// result register is full and a data byte waits behind it.
module self_rekeying_byte_stream_cipher (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [srbsc_pkg::REQ_DW-1:0]  req_tdata,  // key_index, key_value, data_byte
   input  logic [srbsc_pkg::REQ_UW-1:0]  req_tuser,  // cmd[1:0], first_of_call
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [srbsc_pkg::BYTE_W-1:0]  rsp_tdata,  // data_out
   // configuration writes
   input  logic                          csr_we,
   input  logic [srbsc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [srbsc_pkg::CSR_DW-1:0]  csr_wdata
);
   import srbsc_pkg::*;

   // Configuration
   logic              enable_ff;
   logic              direction_ff;
   logic [SPAN_W-1:0] span_ff;

   // Request fields
   cmd_type           req_cmd;
   logic              req_first;
   logic [KEY_AW-1:0] req_key_index;
   logic [BYTE_W-1:0] req_key_value;
   logic [BYTE_W-1:0] req_data_byte;
   logic              req_accept;

   // Front end key position
   logic [KEY_AW-1:0] key_pos_ff;
   logic [KEY_AW-1:0] key_pos_in;
   logic [KEY_AW-1:0] use_pos;
   logic [SPAN_W-1:0] pos_inc;
   logic              req_cipher;

   // Work stage
   logic              s2_valid_ff;
   cmd_type           s2_cmd_ff;
   logic              s2_cipher_ff;
   logic [KEY_AW-1:0] s2_key_index_ff;
   logic [BYTE_W-1:0] s2_key_value_ff;
   logic [BYTE_W-1:0] s2_data_ff;
   logic [KEY_AW-1:0] s2_pos_ff;
   logic              s2_adv;

   // Key ring memory and read forwarding
   logic [BYTE_W-1:0] ring_mem [KEY_BYTES];
   logic [BYTE_W-1:0] ring_rdata_ff;
   logic              byp_ff;
   logic [BYTE_W-1:0] byp_data_ff;
   logic              ring_we;
   logic [KEY_AW-1:0] ring_waddr;
   logic [BYTE_W-1:0] ring_wdata;
   logic [BYTE_W-1:0] key_byte;

   // Copy of ring bytes 0..7 for seed loads
   logic [BYTE_W-1:0] low_ff [LOW_N];
   logic [SEED_W-1:0] low_word;

   // Seed recurrence
   logic [SEED_W-1:0] seed_ff;
   logic [SEED_W-1:0] seed_in;
   logic [MUL_W-1:0]  mul_op;
   logic [SEED_W-1:0] prod_lo;
   logic [SEED_W-1:0] prod_hi;
   logic [SEED_W-1:0] seed_step;
   logic [BYTE_W-1:0] seed_top;
   logic [BYTE_W-1:0] cipher_out;

   // Result register
   logic              rsp_tvalid_ff;
   logic [BYTE_W-1:0] rsp_tdata_ff;

   assign req_cmd       = cmd_type'(req_tuser[CMD_W-1:0]);
   assign req_first     = req_tuser[CMD_W];
   assign req_key_index = req_tdata[KEY_AW-1:0];
   assign req_key_value = req_tdata[2*BYTE_W-1:BYTE_W];
   assign req_data_byte = req_tdata[3*BYTE_W-1:2*BYTE_W];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         direction_ff <= 1'b0;
         span_ff      <= span_of(KEY_LEN_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_DIRECTION: direction_ff <= csr_wdata[0];
            CSR_KEY_LEN:   span_ff      <= span_of(csr_wdata[LEN_W-1:0]);
            default:       ;
         endcase
      end
   end

   // Handshake: the work stage drains unless a data byte waits on a full result register
   assign s2_adv     = s2_valid_ff &&
                       (s2_cmd_ff != CMD_DATA || !rsp_tvalid_ff || rsp_tready);
   assign req_tready = !s2_valid_ff || s2_adv;
   assign req_accept = req_tvalid && req_tready;
   assign req_cipher = (req_cmd == CMD_DATA) && enable_ff;

   // Key position for this byte and the one after it
   always_comb begin
      use_pos = req_first ? '0 : key_pos_ff;
      if ({1'b0, use_pos} >= span_ff) begin
         use_pos = '0;
      end
      pos_inc    = {1'b0, use_pos} + SPAN_W'(1);
      key_pos_in = (pos_inc >= span_ff) ? '0 : pos_inc[KEY_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
      end else if (req_accept && req_cipher) begin
         key_pos_ff <= key_pos_in;
      end
   end

   // Work stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s2_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_cmd_ff       <= req_cmd;
         s2_cipher_ff    <= req_cipher;
         s2_key_index_ff <= req_key_index;
         s2_key_value_ff <= req_key_value;
         s2_data_ff      <= req_data_byte;
         s2_pos_ff       <= use_pos;
      end
   end

   // Ring write port: key writes and the rekeyed byte
   always_comb begin
      ring_we    = 1'b0;
      ring_waddr = s2_pos_ff;
      ring_wdata = seed_in[BYTE_W-1:0];
      if (s2_adv) begin
         case (s2_cmd_ff)
            CMD_KEY_WRITE: begin
               ring_we    = 1'b1;
               ring_waddr = s2_key_index_ff;
               ring_wdata = s2_key_value_ff;
            end
            CMD_DATA: begin
               ring_we = s2_cipher_ff;
            end
            default: ;
         endcase
      end
   end

   // Ring memory with registered read at acceptance
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (req_accept) begin
         ring_rdata_ff <= ring_mem[use_pos];
      end
   end

   // Forward a write that lands on the address being read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         byp_ff      <= ring_we && (ring_waddr == use_pos);
         byp_data_ff <= ring_wdata;
      end
   end

   assign key_byte = byp_ff ? byp_data_ff : ring_rdata_ff;

   // Low ring bytes kept in flops for parallel seed loads
   always_ff @(posedge clock) begin
      if (ring_we && ring_waddr < KEY_AW'(LOW_N)) begin
         low_ff[ring_waddr[LOW_AW-1:0]] <= ring_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < LOW_N; i++) begin
         low_word[i*BYTE_W +: BYTE_W] = low_ff[i];
      end
   end

   // Seed recurrence: seed * seed[39:8] + seed[55:40], mod 2^64
   assign mul_op    = seed_ff[MUL_LSB +: MUL_W];
   assign prod_lo   = SEED_W'(seed_ff[MUL_W-1:0]) * SEED_W'(mul_op);
   assign prod_hi   = {MUL_W'(seed_ff[SEED_W-1:MUL_W] * mul_op), MUL_W'(0)};
   assign seed_step = prod_lo + prod_hi + SEED_W'(seed_ff[ADD_LSB +: ADD_W]);

   always_comb begin
      seed_in = seed_ff;
      if (s2_adv) begin
         case (s2_cmd_ff)
            CMD_SEED_LOAD: seed_in = low_word;
            CMD_DATA: begin
               if (s2_cipher_ff) begin
                  seed_in = (seed_step == '0) ? low_word : seed_step;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Byte transform
   assign seed_top = seed_ff[TOP_LSB +: BYTE_W];

   always_comb begin
      if (!s2_cipher_ff) begin
         cipher_out = s2_data_ff;
      end else if (direction_ff) begin
         cipher_out = (s2_data_ff - seed_top) ^ key_byte;
      end else begin
         cipher_out = (s2_data_ff ^ key_byte) + seed_top;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (s2_adv && s2_cmd_ff == CMD_DATA) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s2_cmd_ff == CMD_DATA) begin
         rsp_tdata_ff <= cipher_out;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: tb/sv/self_rekeying_byte_stream_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the self-rekeying byte stream cipher (directed and random traffic).
module self_rekeying_byte_stream_cipher_tb;
   import srbsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int GAP_MAX        = 14;
   localparam logic [CMD_W-1:0]  CMD_RESERVED = 2'd3;
   localparam logic [CSR_IW-1:0] CSR_UNUSED   = 2'd3;

   // One request transaction, field by field
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] key_index;
      logic [BYTE_W-1:0] key_value;
      logic [BYTE_W-1:0] data_byte;
      logic              first;
   } cipher_req_type;

   // Scoreboard: shadow copy of ring, seed and registers plus expected output bytes
   class cipher_scoreboard_type;
      logic [BYTE_W-1:0] ring [KEY_BYTES];
      logic [SEED_W-1:0] seed;
      int                pos;
      logic              enable;
      logic              decrypt;
      logic [LEN_W-1:0]  key_len;
      logic [BYTE_W-1:0] expected_bytes [$];
      int                mismatches;

      function new();
         seed       = '0;
         pos        = 0;
         enable     = 1'b0;
         decrypt    = 1'b0;
         key_len    = KEY_LEN_RESET;
         mismatches = 0;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function void write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
         case (idx)
            CSR_ENABLE:    enable  = val[0];
            CSR_DIRECTION: decrypt = val[0];
            CSR_KEY_LEN:   key_len = val[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Ring bytes 0..7, byte 0 in the low bits
      function logic [SEED_W-1:0] ring_word();
         logic [SEED_W-1:0] w;
         w = '0;
         for (int i = LOW_N - 1; i >= 0; i--) w = {w[SEED_W-BYTE_W-1:0], ring[i]};
         return w;
      endfunction

      // Cipher one byte and advance seed, ring and key position
      function logic [BYTE_W-1:0] transform_byte(logic [BYTE_W-1:0] b);
         int                span;
         logic [BYTE_W-1:0] top;
         logic [BYTE_W-1:0] k;
         logic [BYTE_W-1:0] r;
         if (key_len == '0) span = 1;
         else if (int'(key_len) > KEY_BYTES) span = KEY_BYTES;
         else span = int'(key_len);
         if (pos >= span) pos = 0;
         top = seed[TOP_LSB +: BYTE_W];
         k   = ring[pos];
         if (decrypt) r = (b - top) ^ k;
         else r = (b ^ k) + top;
         seed = seed * {{(SEED_W-MUL_W){1'b0}}, seed[MUL_LSB +: MUL_W]}
                + {{(SEED_W-ADD_W){1'b0}}, seed[ADD_LSB +: ADD_W]};
         if (seed == '0) seed = ring_word();
         ring[pos] = seed[BYTE_W-1:0];
         pos++;
         if (pos >= span) pos = 0;
         return r;
      endfunction

      function void note_request(cipher_req_type t);
         case (t.cmd)
            CMD_KEY_WRITE: ring[t.key_index] = t.key_value;
            CMD_SEED_LOAD: seed = ring_word();
            CMD_DATA: begin
               if (enable) begin
                  if (t.first) pos = 0;
                  expected_bytes.push_back(transform_byte(t.data_byte));
               end else begin
                  expected_bytes.push_back(t.data_byte);
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_byte(logic [BYTE_W-1:0] got);
         logic [BYTE_W-1:0] want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("data_out %02h with no byte expected", got));
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) report($sformatf("data_out %02h, expected %02h", got, want));
         end
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata;   // key_index, key_value, data_byte
   logic [REQ_UW-1:0]   req_tuser;   // cmd[1:0], first_of_call
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [BYTE_W-1:0]   rsp_tdata;   // data_out
   logic                csr_we;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   cipher_scoreboard_type sb;
   int  req_gap_max;
   int  rsp_gap_max;
   bit  hold_off_req;
   int  idle_cycles;

   self_rekeying_byte_stream_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: record accepted requests, check accepted results
   always @(posedge clock) begin : monitor
      cipher_req_type t;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            t.key_index = req_tdata[BYTE_W-1:0];
            t.key_value = req_tdata[2*BYTE_W-1:BYTE_W];
            t.data_byte = req_tdata[3*BYTE_W-1:2*BYTE_W];
            t.cmd       = req_tuser[CMD_W-1:0];
            t.first     = req_tuser[CMD_W];
            sb.note_request(t);
         end
         if (rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata);
      end
   end

   // Watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("self_rekeying_byte_stream_cipher_tb NOT OK");
         $finish;
      end
   end

   // Result receiver with random stalls and one long hold-off on request
   initial begin : receiver
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   function automatic cipher_req_type mk(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] idx,
                                         logic [BYTE_W-1:0] val, logic [BYTE_W-1:0] d,
                                         logic first);
      cipher_req_type t;
      t.cmd       = cmd;
      t.key_index = idx;
      t.key_value = val;
      t.data_byte = d;
      t.first     = first;
      return t;
   endfunction

   // Mostly data bytes, some key writes, seed loads and reserved commands
   function automatic cipher_req_type random_req();
      cipher_req_type t;
      int             r;
      r = $urandom_range(0, 99);
      t = mk(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      if (r >= 95) t.cmd = CMD_RESERVED;
      else if (r >= 90) t.cmd = CMD_SEED_LOAD;
      else if (r >= 70) t.cmd = CMD_KEY_WRITE;
      return t;
   endfunction

   // Offer one request after a random gap; return at the falling edge after acceptance
   task automatic send_req(cipher_req_type t);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {t.data_byte, t.key_value, t.key_index};
      req_tuser  = {t.first, t.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Wait for all expected bytes, then let the pipeline drain
   task automatic settle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int count, bit data_only);
      cipher_req_type t;
      for (int i = 0; i < count; i++) begin
         t = random_req();
         if (data_only) t.cmd = CMD_DATA;
         send_req(t);
      end
      settle();
   endtask

   // Main sequence
   initial begin
      logic [CSR_DW-1:0] len;
      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_gap_max  = GAP_MAX;
      rsp_gap_max  = GAP_MAX;
      hold_off_req = 1'b0;
      idle_cycles  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Cipher disabled: bytes pass through, first_of_call ignored, reserved command dropped
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h00, 1'b1));
      send_req(mk(CMD_DATA, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_req(mk(CMD_RESERVED, 8'hFF, 8'hFF, 8'h5A, 1'b1));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h5A, 1'b1));
      settle();

      // Fill the whole ring; low eight bytes zero so the seed stays zero at first
      for (int i = 0; i < KEY_BYTES; i++) begin
         send_req(mk(CMD_KEY_WRITE, 8'(i), (i < LOW_N) ? 8'h00 : 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
      settle();
      write_csr(CSR_ENABLE, CSR_DW'(1));
      write_csr(CSR_DIRECTION, CSR_DW'(0));
      write_csr(CSR_KEY_LEN, CSR_DW'(8));

      // Zero seed: reloaded from an all-zero ring word
      send_req(mk(CMD_SEED_LOAD, 8'h00, 8'h00, 8'h00, 1'b0));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'hFF, 1'b1));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h00, 1'b0));

      // Real seed, pack extremes
      for (int i = 0; i < LOW_N; i++) begin
         send_req(mk(CMD_KEY_WRITE, 8'(i), 8'($urandom_range(1, 255)), 8'h00, 1'b0));
      end
      send_req(mk(CMD_SEED_LOAD, 8'h00, 8'h00, 8'h00, 1'b0));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h00, 1'b1));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'hFF, 1'b0));
      settle();

      // Unpack, plus a write to an unused register index
      write_csr(CSR_DIRECTION, CSR_DW'(1));
      write_csr(CSR_UNUSED, '1);
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'hFF, 1'b1));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h00, 1'b0));
      settle();

      // Key length zero acts as one
      write_csr(CSR_KEY_LEN, CSR_DW'(0));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'hA5, 1'b0));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h5A, 1'b0));
      settle();

      // Oversized key length saturates; then shrink so the position lands past the end
      write_csr(CSR_KEY_LEN, CSR_DW'(511));
      for (int i = 0; i < 12; i++) send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'($urandom_range(0, 255)),
                                               i == 0));
      settle();
      write_csr(CSR_KEY_LEN, CSR_DW'(8));
      send_req(mk(CMD_DATA, 8'h00, 8'h00, 8'h3C, 1'b0));
      settle();

      // Random phases over a spread of settings and idling patterns
      for (int p = 0; p < 10; p++) begin
         req_gap_max = (p % 3 == 0) ? 0 : GAP_MAX;
         rsp_gap_max = (p % 4 == 1) ? 0 : GAP_MAX;
         case ($urandom_range(0, 5))
            0:       len = CSR_DW'(0);
            1:       len = CSR_DW'(8);
            2:       len = CSR_DW'(256);
            3:       len = CSR_DW'(511);
            4:       len = CSR_DW'($urandom_range(1, 511));
            default: len = CSR_DW'($urandom_range(8, 256));
         endcase
         write_csr(CSR_ENABLE, CSR_DW'($urandom_range(0, 4) != 0));
         write_csr(CSR_DIRECTION, CSR_DW'($urandom_range(0, 1)));
         write_csr(CSR_KEY_LEN, len);
         run_phase(40, 1'b0);
      end

      // Back-pressure: receiver holds off while the sender streams data bytes
      req_gap_max = 0;
      rsp_gap_max = GAP_MAX;
      write_csr(CSR_ENABLE, CSR_DW'(1));
      hold_off_req = 1'b1;
      run_phase(60, 1'b1);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("self_rekeying_byte_stream_cipher_tb OK");
      end else begin
         $display("self_rekeying_byte_stream_cipher_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/srbsc_pkg.sv
rtl/self_rekeying_byte_stream_cipher.sv
tb/sv/self_rekeying_byte_stream_cipher_tb.sv
